// ===== rtl/sla_pkg.sv =====
// shared types and constants for the sta/lta event trigger
package sla_pkg;

  localparam int unsigned SHORT_DEPTH = 256;
  localparam int unsigned LONG_DEPTH  = 4096;
  localparam int unsigned SAMPLE_BITS = 24;

  localparam int unsigned SPOS_W = $clog2(SHORT_DEPTH);
  localparam int unsigned LPOS_W = $clog2(LONG_DEPTH);
  localparam int unsigned SLEN_W = SPOS_W + 1;
  localparam int unsigned LLEN_W = LPOS_W + 1;
  localparam int unsigned SSUM_W = SAMPLE_BITS + SPOS_W;
  localparam int unsigned LSUM_W = SAMPLE_BITS + LPOS_W;
  localparam int unsigned RATIO_W = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned PROD_W  = RATIO_W + SAMPLE_BITS;

  // register indexes
  localparam logic [1:0] REG_STA_LEN   = 2'd0;
  localparam logic [1:0] REG_LTA_LEN   = 2'd1;
  localparam logic [1:0] REG_RATIO_ON  = 2'd2;
  localparam logic [1:0] REG_RATIO_OFF = 2'd3;

  typedef enum logic [1:0] {
    TR_NONE = 2'd0,
    TR_ON   = 2'd1,
    TR_OFF  = 2'd2
  } transition_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] diff;
    logic                   blk_end;
  } q_entry_t;

  typedef struct packed {
    logic [SLEN_W-1:0]  slen;
    logic [LLEN_W-1:0]  llen;
    logic [RATIO_W-1:0] ratio_on;
    logic [RATIO_W-1:0] ratio_off;
  } cfg_t;

  // first member is the highest bits
  typedef struct packed {
    logic                   block_detected;
    logic                   warming_up;
    transition_e            transition;
    logic                   triggered;
    logic [SAMPLE_BITS-1:0] frozen_long_avg;
    logic [SAMPLE_BITS-1:0] long_avg;
    logic [SAMPLE_BITS-1:0] short_avg;
  } result_t;

endpackage

// ===== rtl/sla_front.sv =====
// input side: takes samples and forms the absolute first difference
module sla_front import sla_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   restart_i,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   last_i,
  input  logic                   full_i,
  output logic                   push_o,
  output q_entry_t               entry_o
);

  logic [SAMPLE_BITS-1:0] prev_q;
  logic [SAMPLE_BITS:0]   delta;
  logic [SAMPLE_BITS:0]   mag;

  assign ready_o = !full_i;
  assign push_o  = valid_i && !full_i;

  always_comb begin
    delta = {sample_i[SAMPLE_BITS-1], sample_i} - {prev_q[SAMPLE_BITS-1], prev_q};
    mag   = delta[SAMPLE_BITS] ? (~delta + 1'b1) : delta;
    entry_o.diff    = mag[SAMPLE_BITS-1:0];
    entry_o.blk_end = last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (restart_i) begin
      prev_q <= '0;
    end else if (push_o) begin
      prev_q <= sample_i;
    end
  end

endmodule

// ===== rtl/sla_fifo.sv =====
// two-entry queue between the input side and the window engine
module sla_fifo import sla_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     clear_i,
  input  logic     push_i,
  input  q_entry_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output q_entry_t data_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  q_entry_t           mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [PTR_W:0]     cnt_q;

  assign full_o  = (cnt_q == (PTR_W+1)'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else if (clear_i) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop_i);
    end
  end

endmodule

// ===== rtl/sla_back.sv =====
// window engine: running sums, serial divider, detector and result register
module sla_back import sla_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     restart_i,
  input  cfg_t     cfg_i,
  input  logic     q_valid_i,
  input  q_entry_t q_data_i,
  output logic     q_pop_o,
  output logic     m_valid_o,
  input  logic     m_ready_i,
  output result_t  m_data_o
);

  localparam int unsigned QW   = SAMPLE_BITS;
  localparam int unsigned REMW = LLEN_W - 1;
  localparam int unsigned CNTW = $clog2(QW);

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_DIV, ST_CMP, ST_DEC, ST_OUT
  } state_e;

  state_e state_q;

  logic [SAMPLE_BITS-1:0] smem [SHORT_DEPTH];
  logic [SAMPLE_BITS-1:0] lmem [LONG_DEPTH];
  logic [SAMPLE_BITS-1:0] srd_q, lrd_q;

  logic [SAMPLE_BITS-1:0] diff_q;
  logic                   be_q;
  logic [SPOS_W-1:0]      spos_q;
  logic [LPOS_W-1:0]      lpos_q;
  logic [SLEN_W-1:0]      sfill_q;
  logic [LLEN_W-1:0]      warm_q;
  logic [SSUM_W-1:0]      ssum_q, ssum_new;
  logic [LSUM_W-1:0]      lsum_q, lsum_new;
  logic [SAMPLE_BITS-1:0] sold, lold;

  logic                   phase_q;
  logic [CNTW-1:0]        cnt_q;
  logic [REMW-1:0]        rem_q, rem_n;
  logic [QW-1:0]          dvd_q, dvd_n;
  logic [REMW:0]          trial;
  logic [LLEN_W-1:0]      div_len;
  logic                   ge;

  logic [SAMPLE_BITS-1:0] sta_q, lta_q, held_q, held_sel;
  logic [PROD_W-1:0]      mul_q;
  logic [PROD_W-1:0]      num;
  logic                   det_q, seen_q, warming;
  result_t                res_q, m_data_q;
  logic                   m_valid_q;

  assign q_pop_o   = (state_q == ST_IDLE) && q_valid_i;
  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;

  // entries not yet written since restart read as zero
  assign sold    = (sfill_q < cfg_i.slen) ? '0 : srd_q;
  assign lold    = (warm_q < cfg_i.llen) ? '0 : lrd_q;
  assign warming = (warm_q < cfg_i.llen);

  assign ssum_new = ssum_q - SSUM_W'(sold) + SSUM_W'(diff_q);
  assign lsum_new = lsum_q - LSUM_W'(lold) + LSUM_W'(diff_q);

  // one restoring division step per cycle
  always_comb begin
    div_len = phase_q ? cfg_i.llen : LLEN_W'(cfg_i.slen);
    trial   = {rem_q, dvd_q[QW-1]};
    ge      = (trial >= div_len);
    rem_n   = ge ? REMW'(trial - div_len) : REMW'(trial);
    dvd_n   = {dvd_q[QW-2:0], ge};
  end

  assign held_sel = det_q ? held_q : lta_q;
  assign num      = PROD_W'({sta_q, 8'h00});

  always_ff @(posedge clk_i) begin
    srd_q <= smem[spos_q];
    lrd_q <= lmem[lpos_q];
    if (state_q == ST_RD) begin
      smem[spos_q] <= diff_q;
      lmem[lpos_q] <= diff_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic        on_n, seen_n;
    transition_e tr_n;
    logic [SAMPLE_BITS-1:0] hold_n;
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      diff_q    <= '0;
      be_q      <= 1'b0;
      spos_q    <= '0;
      lpos_q    <= '0;
      sfill_q   <= '0;
      warm_q    <= '0;
      ssum_q    <= '0;
      lsum_q    <= '0;
      phase_q   <= 1'b0;
      cnt_q     <= '0;
      rem_q     <= '0;
      dvd_q     <= '0;
      sta_q     <= '0;
      lta_q     <= '0;
      held_q    <= '0;
      mul_q     <= '0;
      det_q     <= 1'b0;
      seen_q    <= 1'b0;
      res_q     <= '0;
      m_data_q  <= '0;
      m_valid_q <= 1'b0;
    end else if (restart_i) begin
      state_q   <= ST_IDLE;
      spos_q    <= '0;
      lpos_q    <= '0;
      sfill_q   <= '0;
      warm_q    <= '0;
      ssum_q    <= '0;
      lsum_q    <= '0;
      held_q    <= '0;
      det_q     <= 1'b0;
      seen_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      on_n   = det_q;
      seen_n = seen_q;
      tr_n   = TR_NONE;
      hold_n = held_q;
      // the output state reloads the register itself
      if (m_valid_q && m_ready_i && (state_q != ST_OUT)) m_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            diff_q  <= q_data_i.diff;
            be_q    <= q_data_i.blk_end;
            state_q <= ST_RD;
          end
        end
        ST_RD: begin
          ssum_q <= ssum_new;
          lsum_q <= lsum_new;
          spos_q <= ((SLEN_W'(spos_q) + 1'b1) == cfg_i.slen) ? '0 : spos_q + 1'b1;
          lpos_q <= ((LLEN_W'(lpos_q) + 1'b1) == cfg_i.llen) ? '0 : lpos_q + 1'b1;
          if (sfill_q < cfg_i.slen) sfill_q <= sfill_q + 1'b1;
          rem_q   <= REMW'(ssum_new[SSUM_W-1:QW]);
          dvd_q   <= ssum_new[QW-1:0];
          phase_q <= 1'b0;
          cnt_q   <= CNTW'(QW - 1);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if ((cnt_q == '0) && !phase_q) begin
            sta_q   <= dvd_n;
            rem_q   <= REMW'(lsum_q[LSUM_W-1:QW]);
            dvd_q   <= lsum_q[QW-1:0];
            phase_q <= 1'b1;
            cnt_q   <= CNTW'(QW - 1);
          end else begin
            rem_q <= rem_n;
            dvd_q <= dvd_n;
            if (cnt_q == '0) begin
              lta_q   <= (dvd_n == '0) ? SAMPLE_BITS'(1) : dvd_n;
              state_q <= ST_CMP;
            end else begin
              cnt_q <= cnt_q - 1'b1;
            end
          end
        end
        ST_CMP: begin
          held_q  <= held_sel;
          mul_q   <= (det_q ? cfg_i.ratio_off : cfg_i.ratio_on) * held_sel;
          state_q <= ST_DEC;
        end
        ST_DEC: begin
          if (warming) begin
            warm_q <= warm_q + 1'b1;
          end else if (!det_q && (num >= mul_q)) begin
            on_n = 1'b1; tr_n = TR_ON; hold_n = lta_q;
          end else if (det_q && (num <= mul_q)) begin
            on_n = 1'b0; tr_n = TR_OFF; hold_n = lta_q;
          end
          seen_n = seen_q | on_n;
          det_q  <= on_n;
          held_q <= hold_n;
          res_q.short_avg       <= sta_q;
          res_q.long_avg        <= lta_q;
          res_q.frozen_long_avg <= hold_n;
          res_q.triggered       <= on_n;
          res_q.transition      <= tr_n;
          res_q.warming_up      <= warming;
          res_q.block_detected  <= be_q & seen_n;
          seen_q  <= be_q ? 1'b0 : seen_n;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_valid_q || m_ready_i) begin
            m_data_q  <= res_q;
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/sta_lta_event_trigger_unit.sv =====
// top level of the sta/lta event trigger
// usage:
// - slave channel s_axis_*: one signed 24-bit sample per transaction in tdata,
//   tlast marks the last sample of a processing block
// - master channel m_axis_*: one result per sample with short, long and
//   frozen long averages and the detector flags (layout at the port)
// - config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 sta length, 1 lta length, 2 on ratio, 3 off ratio, ratios in Q8.8);
//   a length write restarts the detector, windows and warm-up
// - results come from a serial divider, one quotient bit a cycle, first
//   for the short average and then for the long one
// - a new sample enters the engine only after the last result is passed on;
//   a two-entry queue lets the input side take samples while the engine is busy
// - reset: all windows read as zero, detector off, config at defaults;
//   no clearing pass, stale window entries are masked by fill counters
// - when the receiver stalls the result is held in the output register,
//   the next result waits in the engine and the queue fills, then
//   s_axis_tready drops
module sta_lta_event_trigger_unit import sla_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] sample
  input  logic        s_axis_tlast,   // block end
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [23:0] short_avg, [47:24] long_avg, [71:48] frozen_long_avg,
  // [72] triggered, [74:73] transition, [75] warming_up,
  // [76] block_detected, [79:77] zero
  output logic [79:0] m_axis_tdata,
  // config port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic [8:0]  sta_len_q;
  logic [12:0] lta_len_q;
  logic [15:0] ratio_on_q, ratio_off_q;
  logic        restart;
  cfg_t        cfg;

  logic        q_push, q_full, q_pop, q_valid;
  q_entry_t    q_in, q_out;
  result_t     res;

  // a length write starts everything over
  assign restart = cfg_we_i && ((cfg_idx_i == REG_STA_LEN) || (cfg_idx_i == REG_LTA_LEN));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sta_len_q   <= 9'd32;
      lta_len_q   <= 13'd1024;
      ratio_on_q  <= 16'd1024;
      ratio_off_q <= 16'd512;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STA_LEN:   sta_len_q   <= cfg_data_i[8:0];
        REG_LTA_LEN:   lta_len_q   <= cfg_data_i[12:0];
        REG_RATIO_ON:  ratio_on_q  <= cfg_data_i;
        REG_RATIO_OFF: ratio_off_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero length acts as one, oversize length acts as the window depth
  always_comb begin
    if (sta_len_q == '0)                          cfg.slen = SLEN_W'(1);
    else if (sta_len_q > SLEN_W'(SHORT_DEPTH))    cfg.slen = SLEN_W'(SHORT_DEPTH);
    else                                          cfg.slen = sta_len_q;
    if (lta_len_q == '0)                          cfg.llen = LLEN_W'(1);
    else if (lta_len_q > LLEN_W'(LONG_DEPTH))     cfg.llen = LLEN_W'(LONG_DEPTH);
    else                                          cfg.llen = lta_len_q;
    cfg.ratio_on  = ratio_on_q;
    cfg.ratio_off = ratio_off_q;
  end

  sla_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .sample_i  (s_axis_tdata),
    .last_i    (s_axis_tlast),
    .full_i    (q_full),
    .push_o    (q_push),
    .entry_o   (q_in)
  );

  sla_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (restart),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  sla_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_data_i  (q_out),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (res)
  );

  assign m_axis_tdata = {3'b000, res};

  // transition code is never the unused one
  a_tr_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[74:73] != 2'd3))
    else $error("bad transition code");

  // long average is clamped to at least one
  a_lta_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[47:24] != '0))
    else $error("long average is zero");

  // a turn-on leaves the detector on, a turn-off leaves it off
  a_tr_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[74:73] != TR_NONE))
      |-> (m_axis_tdata[72] == (m_axis_tdata[74:73] == TR_ON)))
    else $error("transition disagrees with detector state");

  // no decision is made during warm-up
  a_warm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[75]) |-> (m_axis_tdata[74:73] == TR_NONE))
    else $error("transition during warm-up");

endmodule
